// ===== src/swrt_pkg.sv =====
// ----------------------------------------------------------------------------
// swrt_pkg
// Shared types and constants for the sliding window range tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package swrt_pkg;

  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int WIN_LEN_W    = 7;
  localparam int OUT_W        = 32;

  localparam logic [0:0]           REG_WINDOW_LEN   = 1'b0;
  localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RESET = 7'd4;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               restart;
  } item_t;

  typedef struct packed {
    logic signed [31:0] window_max;
    logic signed [31:0] window_min;
    logic [31:0]        window_range;
    logic [31:0]        best_range;
  } result_t;

  // per-cycle command to every cell of one candidate chain
  typedef struct packed {
    logic clear;
    logic age_inc;
    logic shift;
    logic insert;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/swrt_cell.sv =====
// ----------------------------------------------------------------------------
// swrt_cell
// One candidate slot: value, age and valid bit, with local shift/insert.
// ----------------------------------------------------------------------------
`default_nettype none

module swrt_cell #(
  parameter int VAL_W      = 32,
  parameter int AGE_W      = 7,
  parameter bit KEEP_LARGE = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swrt_pkg::cell_ctl_t     ctl,
  input  logic [AGE_W-1:0]        len,
  input  logic signed [VAL_W-1:0] sample,
  input  logic signed [VAL_W-1:0] nxt_val,
  input  logic [AGE_W-1:0]        nxt_age,
  input  logic                    nxt_vld,
  input  logic                    prv_keep,
  output logic signed [VAL_W-1:0] val,
  output logic [AGE_W-1:0]        age,
  output logic                    vld,
  output logic                    keep
);

  logic dom;

  always_comb begin
    if (KEEP_LARGE) begin
      dom = (val <= sample);
    end else begin
      dom = (val >= sample);
    end
    keep = vld && !dom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.clear) begin
      vld <= 1'b0;
    end else if (ctl.age_inc) begin
      if (age < len) begin
        age <= age + AGE_W'(1);
      end
    end else if (ctl.insert) begin
      // surviving cells stay; the first dropped slot after a survivor takes the sample
      if (!keep) begin
        if (prv_keep) begin
          val <= sample;
          age <= '0;
          vld <= 1'b1;
        end else begin
          vld <= 1'b0;
        end
      end
    end else if (ctl.shift) begin
      val <= nxt_val;
      age <= nxt_age;
      vld <= nxt_vld;
    end
  end

endmodule

`default_nettype wire

// ===== src/swrt_chain.sv =====
// ----------------------------------------------------------------------------
// swrt_chain
// Row of candidate cells forming one monotonic queue, oldest at cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module swrt_chain #(
  parameter int DEPTH      = 64,
  parameter int VAL_W      = 32,
  parameter int AGE_W      = 7,
  parameter bit KEEP_LARGE = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swrt_pkg::cell_ctl_t     ctl,
  input  logic [AGE_W-1:0]        len,
  input  logic signed [VAL_W-1:0] sample,
  output logic signed [VAL_W-1:0] front_val,
  output logic [AGE_W-1:0]        front_age,
  output logic                    front_vld
);

  logic signed [VAL_W-1:0] val_a  [DEPTH+1];
  logic [AGE_W-1:0]        age_a  [DEPTH+1];
  logic                    vld_a  [DEPTH+1];
  logic                    keep_a [DEPTH+1];

  // slot past the end is always empty
  assign val_a[DEPTH]  = '0;
  assign age_a[DEPTH]  = '0;
  assign vld_a[DEPTH]  = 1'b0;
  assign keep_a[0]     = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    swrt_cell #(
      .VAL_W      (VAL_W),
      .AGE_W      (AGE_W),
      .KEEP_LARGE (KEEP_LARGE)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .len      (len),
      .sample   (sample),
      .nxt_val  (val_a[i+1]),
      .nxt_age  (age_a[i+1]),
      .nxt_vld  (vld_a[i+1]),
      .prv_keep (keep_a[i]),
      .val      (val_a[i]),
      .age      (age_a[i]),
      .vld      (vld_a[i]),
      .keep     (keep_a[i+1])
    );
  end

  assign front_val = val_a[0];
  assign front_age = age_a[0];
  assign front_vld = vld_a[0];

endmodule

`default_nettype wire

// ===== src/sliding_window_range_tracker.sv =====
// ----------------------------------------------------------------------------
// sliding_window_range_tracker
// Window max/min, range and best range over a sliding window of samples.
// ----------------------------------------------------------------------------
// A request first ages the candidates (or clears them on restart), then
// inserts the sample in both candidate chains, then forms range and best
// range into the output register. Before the insert, each chain drops one
// expired front entry per cycle, both chains in parallel, until neither
// front has aged out; right after window_len is lowered a request can have
// up to WINDOW_MAX such entries to drop. The next request is taken while a
// result waits in the output register; a result still waiting when the
// following one is formed holds that one back. window_len is at byte
// address 0 of the APB port.
`default_nettype none

module sliding_window_range_tracker #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  swrt_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output swrt_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swrt_pkg::ADDR_W-1:0]   paddr,
  input  logic [swrt_pkg::DATA_W-1:0]   pwdata,
  output logic [swrt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AGE_W = $clog2(WINDOW_MAX + 1);
  localparam int VAL_W = SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_OUT
  } state_t;

  state_t state;

  logic [swrt_pkg::WIN_LEN_W-1:0] window_len;
  logic [AGE_W-1:0]               len_eff;
  logic [0:0]                     reg_idx;

  logic signed [VAL_W-1:0] s_reg;
  logic signed [VAL_W-1:0] s_in;
  logic [63:0]             raw64;
  logic [swrt_pkg::OUT_W-1:0] best;

  logic signed [VAL_W-1:0] max_val, min_val;
  logic [AGE_W-1:0]        max_age, min_age;
  logic                    max_vld, min_vld;

  logic accept, expire_max, expire_min, do_insert, out_free;
  swrt_pkg::cell_ctl_t ctl_max, ctl_min;

  logic signed [VAL_W:0]      diff;
  logic [63:0]                diff64;
  logic signed [63:0]         hi64, lo64;
  logic [swrt_pkg::OUT_W-1:0] range_v, best_next;

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];

  always_comb begin
    unique case (reg_idx)
      swrt_pkg::REG_WINDOW_LEN: prdata = swrt_pkg::DATA_W'(window_len);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swrt_pkg::WINDOW_LEN_RESET;
    end else if (psel && penable && pwrite && reg_idx == swrt_pkg::REG_WINDOW_LEN) begin
      window_len <= pwdata[swrt_pkg::WIN_LEN_W-1:0];
    end
  end

  always_comb begin
    if (window_len == '0) begin
      len_eff = AGE_W'(1);
    end else if (32'(window_len) > WINDOW_MAX) begin
      len_eff = AGE_W'(WINDOW_MAX);
    end else begin
      len_eff = AGE_W'(window_len);
    end
  end

  // ---- sequencing ----
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign raw64      = {32'd0, item.sample};
  assign s_in       = raw64[VAL_W-1:0];

  assign expire_max = (state == ST_BUSY) && max_vld && (max_age >= len_eff);
  assign expire_min = (state == ST_BUSY) && min_vld && (min_age >= len_eff);
  assign do_insert  = (state == ST_BUSY) && !expire_max && !expire_min;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    ctl_max.clear   = accept && item.restart;
    ctl_max.age_inc = accept && !item.restart;
    ctl_max.shift   = expire_max;
    ctl_max.insert  = do_insert;
    ctl_min.clear   = accept && item.restart;
    ctl_min.age_inc = accept && !item.restart;
    ctl_min.shift   = expire_min;
    ctl_min.insert  = do_insert;
  end

  swrt_chain #(
    .DEPTH      (WINDOW_MAX),
    .VAL_W      (VAL_W),
    .AGE_W      (AGE_W),
    .KEEP_LARGE (1'b1)
  ) u_max (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_max),
    .len       (len_eff),
    .sample    (s_reg),
    .front_val (max_val),
    .front_age (max_age),
    .front_vld (max_vld)
  );

  swrt_chain #(
    .DEPTH      (WINDOW_MAX),
    .VAL_W      (VAL_W),
    .AGE_W      (AGE_W),
    .KEEP_LARGE (1'b0)
  ) u_min (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_min),
    .len       (len_eff),
    .sample    (s_reg),
    .front_val (min_val),
    .front_age (min_age),
    .front_vld (min_vld)
  );

  // ---- result forming ----
  always_comb begin
    diff   = {max_val[VAL_W-1], max_val} - {min_val[VAL_W-1], min_val};
    diff64 = 64'($unsigned(diff));
    hi64   = 64'(max_val);
    lo64   = 64'(min_val);
    // saturate when the difference does not fit 32 bits
    if (diff64[63:32] != 32'd0) begin
      range_v = '1;
    end else begin
      range_v = diff64[31:0];
    end
    best_next = (range_v > best) ? range_v : best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      best         <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            s_reg <= s_in;
            if (item.restart) begin
              best <= '0;
            end
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (do_insert) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            result.window_max   <= hi64[31:0];
            result.window_min   <= lo64[31:0];
            result.window_range <= range_v;
            result.best_range   <= best_next;
            best                <= best_next;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/swrt_checker.sv =====
// ----------------------------------------------------------------------------
// swrt_checker
// Port-level checks on the range tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swrt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input swrt_pkg::result_t           result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a taken request moves the block out of idle, so item_ready drops after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request taken on consecutive cycles");

  a_max_ge_min: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.window_max >= result.window_min)
    else $error("window max below window min");

  a_range_diff: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.window_range == 32'(result.window_max - result.window_min))
    else $error("range does not match max minus min");

  a_best_ge_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.best_range >= result.window_range)
    else $error("best range below current range");

endmodule

bind sliding_window_range_tracker swrt_checker u_swrt_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sliding_window_range_tracker. A short stimulus
// table covers the extremes, ties, restarts and window length corner values;
// random runs then drive rising, falling, narrow and wide sample streams
// under several window lengths. Every result is checked field by field
// against a hand-computed value or a candidate-queue predictor in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int WIN_CAP      = 64;
  localparam int MAX_CHAIN    = 0;
  localparam int MIN_CHAIN    = 1;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_TAIL   = 80;   // room for a request plus a full shrink
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 165;

  localparam logic [swrt_pkg::ADDR_W-1:0] WIN_LEN_ADDR =
    swrt_pkg::ADDR_W'(4 * swrt_pkg::REG_WINDOW_LEN);

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic [31:0]        U_MAX = 32'hFFFF_FFFF;
  localparam swrt_pkg::result_t  NONE  = '0;

  localparam logic [swrt_pkg::WIN_LEN_W-1:0] PHASE_WIN [11] = '{
    7'd1, 7'd64, 7'd3, 7'd127, 7'd2, 7'd16, 7'd0, 7'd63, 7'd5, 7'd65, 7'd4
  };

  typedef enum logic {ROW_SAMPLE, ROW_SET_WIN} row_kind_t;
  typedef enum {SRC_ANY, SRC_NARROW, SRC_EDGES, SRC_RISE, SRC_FALL} src_mode_t;
  typedef enum {RX_STREAM, RX_EVERY_THIRD, RX_MOSTLY, RX_SELDOM} rx_mode_t;

  typedef struct {
    row_kind_t                      kind;
    swrt_pkg::item_t                req;
    bit                             pinned;
    swrt_pkg::result_t              want;
    logic [swrt_pkg::WIN_LEN_W-1:0] win;
  } plan_row_t;

  typedef struct {
    bit                pinned;
    swrt_pkg::result_t want;
  } pin_t;

  // pinned rows carry a hand-computed result; the rest use the predictor
  plan_row_t plan [25] = '{
    '{ROW_SAMPLE,  '{32'sd0, 1'b1},   1'b1, '{32'sd0, 32'sd0, 32'd0, 32'd0}, 7'd0},
    '{ROW_SAMPLE,  '{S_MAX, 1'b0},    1'b1,
      '{S_MAX, 32'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 7'd0},
    '{ROW_SAMPLE,  '{S_MIN, 1'b0},    1'b1, '{S_MAX, S_MIN, U_MAX, U_MAX}, 7'd0},
    '{ROW_SAMPLE,  '{32'sd5, 1'b0},   1'b1, '{S_MAX, S_MIN, U_MAX, U_MAX}, 7'd0},
    '{ROW_SAMPLE,  '{32'sd5, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd5, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd5, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{-32'sd1, 1'b1},  1'b1, '{-32'sd1, -32'sd1, 32'd0, 32'd0}, 7'd0},
    '{ROW_SET_WIN, '{32'sd0, 1'b0},   1'b0, NONE, 7'd64},
    '{ROW_SAMPLE,  '{32'sd1, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd2, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd3, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd4, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd5, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{32'sd6, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SET_WIN, '{32'sd0, 1'b0},   1'b0, NONE, 7'd2},
    '{ROW_SAMPLE,  '{32'sd7, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SET_WIN, '{32'sd0, 1'b0},   1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{-32'sd7, 1'b0},  1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{S_MIN, 1'b0},    1'b0, NONE, 7'd0},
    '{ROW_SET_WIN, '{32'sd0, 1'b0},   1'b0, NONE, 7'd127},
    '{ROW_SAMPLE,  '{32'sd100, 1'b0}, 1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{-32'sd100, 1'b0}, 1'b0, NONE, 7'd0},
    '{ROW_SAMPLE,  '{S_MAX, 1'b1},    1'b1, '{S_MAX, S_MAX, 32'd0, 32'd0}, 7'd0},
    '{ROW_SAMPLE,  '{S_MIN, 1'b0},    1'b1, '{S_MAX, S_MIN, U_MAX, U_MAX}, 7'd0}
  };

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_ready;
  swrt_pkg::item_t               item         = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  swrt_pkg::result_t             result;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [swrt_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [swrt_pkg::DATA_W-1:0]   pwdata       = '0;
  logic [swrt_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // predictor state: chain 0 keeps maximum candidates, chain 1 minimum
  logic signed [31:0]             cand_val [2][WIN_CAP];
  logic [6:0]                     cand_age [2][WIN_CAP];
  int                             cand_cnt [2] = '{0, 0};
  logic [31:0]                    best_seen = '0;
  logic [swrt_pkg::WIN_LEN_W-1:0] win_len_shadow = swrt_pkg::WINDOW_LEN_RESET;

  pin_t              pin_q[$];
  swrt_pkg::result_t pending_ranges[$];
  int                fails = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  bit                hold_asked = 1'b0;
  string             field_name [4] = '{"best_range", "window_range", "window_min",
                                        "window_max"};

  sliding_window_range_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sliding_window_range_tracker");
      $finish;
    end
  end

  // age, expire from the front, drop dominated tail entries, append sample
  function automatic void slide_chain(input int c, input logic signed [31:0] s,
                                      input int len);
    int n;
    int drop;
    n = cand_cnt[c];
    drop = 0;
    for (int i = 0; i < n; i++)
      if (cand_age[c][i] < len) cand_age[c][i]++;
    while (drop < n && cand_age[c][drop] >= len) drop++;
    for (int i = drop; i < n; i++) begin
      cand_val[c][i-drop] = cand_val[c][i];
      cand_age[c][i-drop] = cand_age[c][i];
    end
    n -= drop;
    // ties: the older equal entry goes in both chains
    while (n > 0 && (c == MAX_CHAIN ? cand_val[c][n-1] <= s : cand_val[c][n-1] >= s))
      n--;
    if (n < WIN_CAP) begin
      cand_val[c][n] = s;
      cand_age[c][n] = '0;
      n++;
    end
    cand_cnt[c] = n;
  endfunction

  function automatic swrt_pkg::result_t track_range(input swrt_pkg::item_t it);
    int                len;
    longint            span;
    swrt_pkg::result_t r;
    len = (win_len_shadow == 0) ? 1 :
          (win_len_shadow > WIN_CAP) ? WIN_CAP : int'(win_len_shadow);
    if (it.restart) begin
      cand_cnt[MAX_CHAIN] = 0;
      cand_cnt[MIN_CHAIN] = 0;
      best_seen = '0;
    end
    slide_chain(MAX_CHAIN, it.sample, len);
    slide_chain(MIN_CHAIN, it.sample, len);
    r.window_max = cand_val[MAX_CHAIN][0];
    r.window_min = cand_val[MIN_CHAIN][0];
    span = longint'(r.window_max) - longint'(r.window_min);
    r.window_range = (span > longint'(U_MAX)) ? U_MAX : span[31:0];
    if (r.window_range > best_seen) best_seen = r.window_range;
    r.best_range = best_seen;
    return r;
  endfunction

  // request accepted: queue its expected result
  always @(posedge clk) begin
    pin_t              pin;
    swrt_pkg::result_t r;
    if (!rst && item_valid && item_ready) begin
      pin = pin_q[0];
      pin_q.delete(0);
      r = track_range(item);
      if (pin.pinned) r = pin.want;
      pending_ranges = {pending_ranges, r};
    end
  end

  always @(posedge clk) begin
    swrt_pkg::result_t       w;
    logic [3:0][31:0]        w_f;
    logic [3:0][31:0]        g_f;
    if (!rst && result_valid && result_ready) begin
      if (pending_ranges.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, got %h", $time, result);
      end else begin
        w = pending_ranges[0];
        pending_ranges.delete(0);
        w_f = w;
        g_f = result;
        for (int f = 3; f >= 0; f--)
          if (g_f[f] !== w_f[f]) begin
            fails++;
            $display("%0t: %s expected %h got %h", $time, field_name[f], w_f[f], g_f[f]);
          end
      end
    end
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    mode = RX_STREAM;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_asked) begin
        hold_asked = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_STREAM:      result_ready <= 1'b1;
        RX_EVERY_THIRD: result_ready <= (tick % 3) != 0;
        RX_MOSTLY:      result_ready <= $urandom_range(0, 9) < 7;
        default:        result_ready <= $urandom_range(0, 9) < 2;
      endcase
    end
  end

  task automatic check_window();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WIN_LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== swrt_pkg::DATA_W'(win_len_shadow)) begin
      fails++;
      $display("%0t: window_len read expected %0d got %0d", $time, win_len_shadow, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [swrt_pkg::WIN_LEN_W-1:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIN_LEN_ADDR;
    pwdata  <= swrt_pkg::DATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    win_len_shadow = len;
    check_window();
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic send(input swrt_pkg::item_t it, input bit pinned,
                      input swrt_pkg::result_t want);
    int   gap;
    pin_t pin;
    pin.pinned = pinned;
    pin.want   = want;
    pin_q = {pin_q, pin};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending_ranges.size() != 0 || pin_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    src_mode_t          mode;
    int                 run_left;
    logic signed [31:0] last;
    swrt_pkg::item_t    it;
    mode = SRC_ANY;
    run_left = 0;
    last = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    check_window();

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SET_WIN) begin
        settle();
        set_window(plan[i].win);
      end else begin
        send(plan[i].req, plan[i].pinned, plan[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_window(p < 11 ? PHASE_WIN[p] : swrt_pkg::WIN_LEN_W'($urandom_range(0, 127)));
      run_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 50 && p % 4 == 1) hold_asked = 1'b1;
        if (run_left == 0) begin
          mode = src_mode_t'($urandom_range(0, 4));
          run_left = $urandom_range(1, 48);
        end
        run_left--;
        case (mode)
          SRC_ANY:    it.sample = $urandom;
          SRC_NARROW: it.sample = int'($urandom_range(0, 8)) - 4;
          SRC_EDGES:
            case ($urandom_range(0, 3))
              0:       it.sample = S_MAX;
              1:       it.sample = S_MIN;
              2:       it.sample = 32'sd0;
              default: it.sample = -32'sd1;
            endcase
          SRC_RISE:   it.sample = last + int'($urandom_range(0, 3));
          default:    it.sample = last - int'($urandom_range(0, 3));
        endcase
        it.restart = ($urandom_range(0, 39) == 0);
        send(it, 1'b0, NONE);
        last = it.sample;
      end
    end

    settle();
    if (fails == 0) begin
      $display("PASS sliding_window_range_tracker");
    end else begin
      $display("FAIL sliding_window_range_tracker");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/swrt_pkg.sv
src/swrt_cell.sv
src/swrt_chain.sv
src/sliding_window_range_tracker.sv
src/swrt_checker.sv
tb/sv/tb.sv
